// ===== rtl/rtk_pkg.sv =====
// rtk_pkg: constants shared by the proximity tracker modules.
// Holds divider and multiplier widths, register indexes, zone codes and reset values.
// No dependencies.
package rtk_pkg;
    localparam int DEF_WINDOW_DEPTH = 8;

    localparam int DIV_DVD_W = 50;
    localparam int DIV_DVS_W = 34;
    localparam int DIV_Q_W   = 17;

    localparam int MUL_A_W = 18;
    localparam int MUL_B_W = 35;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int EST_W = 25;
    localparam int PV_W  = 32;

    localparam logic [9:0] HYSTERESIS = 10'd5;

    localparam logic [2:0] REG_APPROACH  = 3'd0;
    localparam logic [2:0] REG_PROXIMITY = 3'd1;
    localparam logic [2:0] REG_DEBOUNCE  = 3'd2;
    localparam logic [2:0] REG_PNOISE    = 3'd3;
    localparam logic [2:0] REG_MNOISE    = 3'd4;
    localparam logic [2:0] REG_INITERR   = 3'd5;

    localparam logic [1:0] ZONE_IDLE      = 2'd0;
    localparam logic [1:0] ZONE_APPROACH  = 2'd1;
    localparam logic [1:0] ZONE_PROXIMITY = 2'd2;
    localparam logic [1:0] ZONE_LOST      = 2'd3;

    localparam logic [7:0]  RST_APPROACH  = 8'hBA;   // -70
    localparam logic [7:0]  RST_PROXIMITY = 8'hCE;   // -50
    localparam logic [7:0]  RST_DEBOUNCE  = 8'd3;
    localparam logic [15:0] RST_PNOISE    = 16'd26;
    localparam logic [15:0] RST_MNOISE    = 16'd1024;
    localparam logic [15:0] RST_INITERR   = 16'd2560;
endpackage

// ===== rtl/rssi_proximity_tracker.sv =====
// rssi_proximity_tracker: RSSI window average, scalar Kalman filter and zone machine.
// Depends on rtk_pkg, rtk_div and rtk_mul.
//
// Usage:
//  Input stream (i_s_axis_*): one word per RSSI sample, tdata[7:0] signed dBm.
//  Output stream (o_m_axis_*): one word per sample with the filtered value,
//  window average, estimator flag, zone, previous zone and change flag.
//  APB port: six registers at byte addresses 0,4,..,20 (approach level,
//  proximity level, debounce count, process noise, measurement noise,
//  initial error). Write only while no sample is in flight.
//  Steps: with the Kalman update a sample passes window update, average
//  divide, gain setup, gain divide, two multiplier passes, variance write
//  and finish. A zero gain denominator skips the gain divide; the seeding
//  sample goes from gain setup to finish, and before the estimator starts
//  the average divide goes straight to finish. One sample is in work at a
//  time; tready is high only when idle, so a new sample is taken only
//  after the last one has left the finish step.
//  The output word sits in a register: the next sample is accepted while it
//  waits, and the finish step holds until the receiver takes the old word.
//  Reset: synchronous, active low; registers take their defaults, the
//  window empties, the estimator is unseeded and the zone is idle.
module rssi_proximity_tracker
    import rtk_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rssi_sample
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] filtered_rssi, [15:8] window_average, [16] estimator_active,
    // [18:17] zone_state, [20:19] previous_zone, [21] zone_changed, [23:22] zero
    output logic [23:0] o_m_axis_tdata,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);
    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = 8 + $clog2(WINDOW_DEPTH) + 1;
    localparam logic [FILL_W-1:0] FULL  = FILL_W'(WINDOW_DEPTH);
    localparam logic [FILL_W-1:0] HALF  = FILL_W'(WINDOW_DEPTH / 2);
    localparam logic [SLOT_W-1:0] LASTS = SLOT_W'(WINDOW_DEPTH - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SUM  = 4'd1;
    localparam logic [3:0] S_ADIV = 4'd2;
    localparam logic [3:0] S_KAL  = 4'd3;
    localparam logic [3:0] S_KDIV = 4'd4;
    localparam logic [3:0] S_MA   = 4'd5;
    localparam logic [3:0] S_MB   = 4'd6;
    localparam logic [3:0] S_PU   = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    // configuration
    logic [7:0]  r_app, r_prox, r_dbc;
    logic [15:0] r_qn, r_rn, r_ie;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign cfg_idx  = i_paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_app  <= RST_APPROACH;
            r_prox <= RST_PROXIMITY;
            r_dbc  <= RST_DEBOUNCE;
            r_qn   <= RST_PNOISE;
            r_rn   <= RST_MNOISE;
            r_ie   <= RST_INITERR;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_APPROACH:  r_app  <= i_pwdata[7:0];
                REG_PROXIMITY: r_prox <= i_pwdata[7:0];
                REG_DEBOUNCE:  r_dbc  <= i_pwdata[7:0];
                REG_PNOISE:    r_qn   <= i_pwdata[15:0];
                REG_MNOISE:    r_rn   <= i_pwdata[15:0];
                REG_INITERR:   r_ie   <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_APPROACH:  o_prdata = {{24{r_app[7]}}, r_app};
            REG_PROXIMITY: o_prdata = {{24{r_prox[7]}}, r_prox};
            REG_DEBOUNCE:  o_prdata = {24'd0, r_dbc};
            REG_PNOISE:    o_prdata = {16'd0, r_qn};
            REG_MNOISE:    o_prdata = {16'd0, r_rn};
            REG_INITERR:   o_prdata = {16'd0, r_ie};
            default:       o_prdata = '0;
        endcase
    end

    // sequencer state and datapath registers
    logic [3:0]        r_state;
    logic [7:0]        r_z, r_old;
    logic [7:0]        r_win [WINDOW_DEPTH];
    logic [SLOT_W-1:0] r_slot;
    logic [FILL_W-1:0] r_fill;
    logic signed [SUM_W-1:0] r_sum;
    logic [7:0]        r_avg;
    logic signed [EST_W-1:0] r_est;
    logic [PV_W-1:0]   r_pv;
    logic [PV_W:0]     r_ppred;
    logic [DIV_Q_W-1:0] r_k;
    logic              r_seeded;
    logic [1:0]        r_zone, r_prev;
    logic [7:0]        r_dcnt;
    logic              r_ovalid;
    logic [23:0]       r_odata;

    logic in_acc;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    // window memory: read the slot being replaced, then overwrite it
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old        <= r_win[r_slot];
            r_win[r_slot] <= i_s_axis_tdata;
            r_z          <= i_s_axis_tdata;
        end
    end

    // running sum update; the average divide starts from the updated sum and count
    logic signed [SUM_W-1:0] sum_new;
    logic [SUM_W-1:0]        sum_abs;
    logic [FILL_W-1:0]       fill_nx;
    always_comb begin
        sum_new = r_sum + SUM_W'(signed'(r_z));
        if (r_fill == FULL) begin
            sum_new = sum_new - SUM_W'(signed'(r_old));
        end
        sum_abs = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : sum_new;
        fill_nx = (r_fill == FULL) ? r_fill : r_fill + 1'b1;
    end

    // Kalman predict terms
    logic [PV_W:0]        ppred;
    logic [DIV_DVS_W-1:0] den;
    always_comb begin
        ppred = {1'b0, r_pv} + (PV_W+1)'({r_qn, 8'd0});
        den   = DIV_DVS_W'(ppred) + DIV_DVS_W'({r_rn, 8'd0});
    end

    // shared divider
    logic                 div_start, div_done;
    logic [DIV_DVD_W-1:0] div_dvd;
    logic [DIV_DVS_W-1:0] div_dvs;
    logic [DIV_Q_W-1:0]   div_q;
    always_comb begin
        div_start = 1'b0;
        div_dvd   = DIV_DVD_W'(sum_abs);
        div_dvs   = DIV_DVS_W'(fill_nx);
        if (r_state == S_SUM) begin
            div_start = 1'b1;
        end else if (r_state == S_KAL) begin
            div_start = r_seeded && (den != '0);
            div_dvd   = DIV_DVD_W'({ppred, 16'd0});
            div_dvs   = den;
        end
    end

    rtk_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // shared multiplier: gain times innovation, then (1-K) times Ppred
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    logic signed [25:0]        diff;
    always_comb begin
        diff = {{2{r_z[7]}}, r_z, 16'd0} - {r_est[EST_W-1], r_est};
        if (r_state == S_MA) begin
            mul_a = MUL_A_W'({1'b0, r_k});
            mul_b = MUL_B_W'(diff);
        end else begin
            mul_a = MUL_A_W'(18'd65536 - {1'b0, r_k});
            mul_b = MUL_B_W'({1'b0, r_ppred});
        end
    end

    rtk_mul u_mul (
        .i_clk     (i_clk),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_product (mul_p)
    );

    // round the gain step to nearest, ties away from zero
    logic [MUL_P_W-1:0] step_mag;
    logic [MUL_P_W-1:0] step_rnd;
    logic signed [EST_W-1:0] step;
    always_comb begin
        step_mag = mul_p[MUL_P_W-1] ? MUL_P_W'(-mul_p) : MUL_P_W'(mul_p);
        step_rnd = (step_mag + MUL_P_W'(32768)) >> 16;
        step     = mul_p[MUL_P_W-1] ? EST_W'(-step_rnd) : EST_W'(step_rnd);
    end

    // filtered value and zone decision
    logic [EST_W-1:0]  est_mag;
    logic [EST_W-1:0]  est_rnd;
    logic signed [9:0] est_int;
    logic signed [9:0] filt;
    logic signed [9:0] app_s, prox_s;
    logic [7:0]        dcnt_inc, n_dcnt;
    logic [1:0]        n_zone;
    logic              qualify;
    logic [1:0]        target;
    always_comb begin
        est_mag = r_est[EST_W-1] ? EST_W'(-r_est) : EST_W'(r_est);
        est_rnd = (est_mag + EST_W'(32768)) >> 16;
        est_int = r_est[EST_W-1] ? -10'(est_rnd) : 10'(est_rnd);
        if (r_seeded) begin
            if (est_int > 10'sd127) begin
                filt = 10'sd127;
            end else if (est_int < -10'sd128) begin
                filt = -10'sd128;
            end else begin
                filt = est_int;
            end
        end else begin
            filt = 10'(signed'(r_avg));
        end

        app_s  = 10'(signed'(r_app));
        prox_s = 10'(signed'(r_prox));
        qualify = 1'b0;
        target  = r_zone;
        case (r_zone)
            ZONE_IDLE, ZONE_LOST: begin
                if (filt > app_s) begin
                    qualify = 1'b1;
                    target  = ZONE_APPROACH;
                end
            end
            ZONE_APPROACH: begin
                if (filt > prox_s) begin
                    qualify = 1'b1;
                    target  = ZONE_PROXIMITY;
                end else if (filt < app_s - signed'(HYSTERESIS)) begin
                    qualify = 1'b1;
                    target  = ZONE_LOST;
                end
            end
            default: begin
                if (filt < prox_s - signed'(HYSTERESIS)) begin
                    qualify = 1'b1;
                    target  = ZONE_APPROACH;
                end
            end
        endcase

        dcnt_inc = (r_dcnt == 8'hFF) ? r_dcnt : r_dcnt + 8'd1;
        n_zone   = r_zone;
        n_dcnt   = 8'd0;
        if (qualify) begin
            if (dcnt_inc >= r_dbc) begin
                n_zone = target;
            end else begin
                n_dcnt = dcnt_inc;
            end
        end
    end

    logic fin_go;
    assign fin_go = (r_state == S_FIN) && (!r_ovalid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_slot   <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
            r_est    <= '0;
            r_pv     <= PV_W'({RST_INITERR, 8'd0});
            r_seeded <= 1'b0;
            r_zone   <= ZONE_IDLE;
            r_prev   <= ZONE_IDLE;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready && !fin_go) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sum   <= sum_new;
                    r_slot  <= (r_slot == LASTS) ? '0 : r_slot + 1'b1;
                    if (r_fill != FULL) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_ADIV;
                end
                S_ADIV: begin
                    if (div_done) begin
                        r_avg   <= r_sum[SUM_W-1] ? 8'(-div_q) : 8'(div_q);
                        r_state <= (r_fill >= HALF) ? S_KAL : S_FIN;
                    end
                end
                S_KAL: begin
                    r_ppred <= ppred;
                    if (!r_seeded) begin
                        r_est    <= EST_W'({{1{r_z[7]}}, r_z, 16'd0});
                        r_pv     <= PV_W'({r_ie, 8'd0});
                        r_seeded <= 1'b1;
                        r_state  <= S_FIN;
                    end else if (den == '0) begin
                        r_k     <= '0;
                        r_state <= S_MA;
                    end else begin
                        r_state <= S_KDIV;
                    end
                end
                S_KDIV: begin
                    if (div_done) begin
                        r_k     <= div_q;
                        r_state <= S_MA;
                    end
                end
                S_MA: begin
                    r_state <= S_MB;
                end
                S_MB: begin
                    r_est   <= r_est + step;
                    r_state <= S_PU;
                end
                S_PU: begin
                    r_pv    <= mul_p[PV_W+15:16];
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (fin_go) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {2'b00, (n_zone != r_zone),
                                     (n_zone != r_zone) ? r_zone : r_prev,
                                     n_zone, r_seeded, r_avg, filt[7:0]};
                        if (n_zone != r_zone) begin
                            r_prev <= r_zone;
                        end
                        r_zone  <= n_zone;
                        r_dcnt  <= n_dcnt;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/rtk_div.sv =====
// rtk_div: restoring divider, one quotient bit per cycle.
// Quotient must fit DIV_Q_W bits (upper dividend part below the divisor).
// Depends on rtk_pkg.
module rtk_div
    import rtk_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_DVD_W-1:0] i_dividend,
    input  logic [DIV_DVS_W-1:0] i_divisor,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quotient
);
    localparam int REM_W = DIV_DVS_W + 1;
    localparam int CNT_W = $clog2(DIV_Q_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(DIV_Q_W - 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [DIV_Q_W-1:0] r_lo;
    logic [DIV_DVS_W-1:0] r_dvs;

    logic [REM_W-1:0]   trial;
    logic               fits;
    logic [REM_W-1:0]   n_rem;
    logic [DIV_Q_W-1:0] n_lo;

    always_comb begin
        trial = {r_rem[REM_W-2:0], r_lo[DIV_Q_W-1]};
        fits  = trial >= {1'b0, r_dvs};
        n_rem = fits ? trial - {1'b0, r_dvs} : trial;
        n_lo  = {r_lo[DIV_Q_W-2:0], fits};
    end

    assign o_done     = r_busy && (r_cnt == LAST);
    assign o_quotient = n_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == LAST) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= REM_W'(i_dividend[DIV_DVD_W-1:DIV_Q_W]);
            r_lo  <= i_dividend[DIV_Q_W-1:0];
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_lo  <= n_lo;
        end
    end
endmodule

// ===== rtl/rtk_mul.sv =====
// rtk_mul: shared signed multiplier with a registered product.
// Depends on rtk_pkg.
module rtk_mul
    import rtk_pkg::*;
(
    input  logic                      i_clk,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output logic signed [MUL_P_W-1:0] o_product
);
    logic signed [MUL_P_W-1:0] r_product;

    always_ff @(posedge i_clk) begin
        r_product <= i_a * i_b;
    end

    assign o_product = r_product;
endmodule
